FILE: rtl/bloom_filter_test_and_insert_assert.svh
// ----------------------------------------------------------------------------
// bloom filter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_TEST_AND_INSERT_ASSERT_SVH
`define BLOOM_FILTER_TEST_AND_INSERT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BFTI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bloom filter assertion failed");

// antecedent implies consequent in the next cycle
`define BFTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bloom filter assertion failed");

`endif

FILE: rtl/bfti_pkg.sv
// ----------------------------------------------------------------------------
// bfti_pkg
// shared constants, state encoding and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package bfti_pkg;

  localparam int unsigned BITMAP_BYTES_DEF = 48 * 1024;
  localparam int unsigned HASH_PROBES_DEF  = 4;

  localparam logic [31:0] SEED_ONE  = 32'h811c9dc5;
  localparam logic [31:0] SEED_TWO  = 32'h7ee3623b;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  localparam logic CMD_KEY_BYTE  = 1'b0;
  localparam logic CMD_UNTRACKED = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RED,
    S_FIX,
    S_RD,
    S_TEST,
    S_WRD,
    S_WSET,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic hash_byte;
    logic key_end;
    logic untracked;
    logic mul;
    logic red;
    logic fix;
    logic test;
    logic wr_set;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic k_last;
    logic bit_set;
    logic all_set;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/bfti_bitmap.sv
// ----------------------------------------------------------------------------
// bfti_bitmap
// membership bitmap ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bfti_bitmap #(
  parameter int unsigned DEPTH  = bfti_pkg::BITMAP_BYTES_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bfti_ctrl.sv
// ----------------------------------------------------------------------------
// bfti_ctrl
// sequencer: clearing pass, byte intake, probe test pass, set pass, emit
// ----------------------------------------------------------------------------
`default_nettype none

module bfti_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            cmd,
  input  wire logic            last_byte,
  input  wire bfti_pkg::stat_t stat,
  output bfti_pkg::cmd_t       ctl
);

  bfti_pkg::state_t state;
  bfti_pkg::state_t state_next;
  logic             take;

  assign in_stall = (state != bfti_pkg::S_IDLE);
  assign take     = in_valid && (state == bfti_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfti_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bfti_pkg::S_CLEAR: begin
        if (stat.clr_last) state_next = bfti_pkg::S_IDLE;
      end
      bfti_pkg::S_IDLE: begin
        if (take) begin
          if (cmd == bfti_pkg::CMD_UNTRACKED) begin
            state_next = bfti_pkg::S_EMIT;
          end else if (last_byte) begin
            state_next = bfti_pkg::S_MUL;
          end
        end
      end
      bfti_pkg::S_MUL:  state_next = bfti_pkg::S_RED;
      bfti_pkg::S_RED:  state_next = bfti_pkg::S_FIX;
      bfti_pkg::S_FIX:  state_next = bfti_pkg::S_RD;
      bfti_pkg::S_RD:   state_next = bfti_pkg::S_TEST;
      bfti_pkg::S_TEST: begin
        if (!stat.k_last) begin
          state_next = bfti_pkg::S_MUL;
        end else if (stat.all_set && stat.bit_set) begin
          state_next = bfti_pkg::S_EMIT;
        end else begin
          state_next = bfti_pkg::S_WRD;
        end
      end
      bfti_pkg::S_WRD:  state_next = bfti_pkg::S_WSET;
      bfti_pkg::S_WSET: begin
        state_next = stat.k_last ? bfti_pkg::S_EMIT : bfti_pkg::S_WRD;
      end
      bfti_pkg::S_EMIT: begin
        if (stat.out_free) state_next = bfti_pkg::S_IDLE;
      end
      default: state_next = bfti_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      bfti_pkg::S_CLEAR: ctl.clr_step = 1'b1;
      bfti_pkg::S_IDLE: begin
        if (take) begin
          if (cmd == bfti_pkg::CMD_UNTRACKED) begin
            ctl.untracked = 1'b1;
          end else if (last_byte) begin
            ctl.key_end = 1'b1;
          end else begin
            ctl.hash_byte = 1'b1;
          end
        end
      end
      bfti_pkg::S_MUL:  ctl.mul    = 1'b1;
      bfti_pkg::S_RED:  ctl.red    = 1'b1;
      bfti_pkg::S_FIX:  ctl.fix    = 1'b1;
      bfti_pkg::S_RD:   ctl        = '0;
      bfti_pkg::S_TEST: ctl.test   = 1'b1;
      bfti_pkg::S_WRD:  ctl        = '0;
      bfti_pkg::S_WSET: ctl.wr_set = 1'b1;
      bfti_pkg::S_EMIT: ctl.emit   = stat.out_free;
      default:          ctl        = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bfti_dp.sv
// ----------------------------------------------------------------------------
// bfti_dp
// running hashes, probe index unit, bitmap access, counters, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "bloom_filter_test_and_insert_assert.svh"

module bfti_dp #(
  parameter int unsigned BITMAP_BYTES = bfti_pkg::BITMAP_BYTES_DEF,
  parameter int unsigned HASH_PROBES  = bfti_pkg::HASH_PROBES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     key_byte,
  input  wire bfti_pkg::cmd_t ctl,
  output bfti_pkg::stat_t     stat,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                returning,
  output logic [31:0]         det_total,
  output logic [31:0]         uniq_total,
  output logic [31:0]         det_since_rst,
  output logic [31:0]         uniq_since_rst,
  output logic [31:0]         session_returning
);

  localparam int unsigned BITMAP_BITS = 8 * BITMAP_BYTES;
  localparam int unsigned BIT_W       = $clog2(BITMAP_BITS);
  localparam int unsigned ADDR_W      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned K_W         = (HASH_PROBES > 1) ? $clog2(HASH_PROBES) : 1;
  localparam logic [31:0] BITS32      = 32'(BITMAP_BITS);
  localparam logic [31:0] BITS2X      = 32'(2 * BITMAP_BITS);
  // floor(2^32 / bits), quotient estimate is low by at most one
  localparam logic [63:0] RECIP64     = (64'd1 << 32) / 64'(BITMAP_BITS);
  localparam logic [31:0] RECIP       = RECIP64[31:0];
  localparam logic [K_W-1:0]    K_LAST   = K_W'(HASH_PROBES - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(BITMAP_BYTES - 1);

  logic [31:0] hash_one;
  logic [31:0] hash_two;
  logic [31:0] hash_one_next;
  logic [31:0] hash_two_next;

  logic [31:0] acc;
  logic [31:0] step;
  logic [31:0] mod_x;
  logic [63:0] mod_prod;
  logic [31:0] mod_rem;
  logic [31:0] mod_q;
  logic [31:0] mod_qb;
  logic [31:0] mod_fix;

  logic [BIT_W-1:0]  idx [HASH_PROBES];
  logic [K_W-1:0]    k;
  logic [BIT_W-1:0]  idx_k;
  logic [BIT_W-1:0]  idx_sh;
  logic [ADDR_W-1:0] probe_addr;
  logic [7:0]        mask;

  logic [ADDR_W-1:0] clr_addr;
  logic              all_set;
  logic              untracked;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  logic [31:0] tot_det;
  logic [31:0] tot_uniq;
  logic [31:0] ses_det;
  logic [31:0] ses_uniq;
  logic [31:0] ses_ret;
  logic        is_ret;
  logic        is_new;

  // fnv-1a step on both running hashes
  assign hash_one_next = (hash_one ^ {24'd0, key_byte}) * bfti_pkg::FNV_PRIME;
  assign hash_two_next = (hash_two ^ {24'd0, key_byte}) * bfti_pkg::FNV_PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_one <= bfti_pkg::SEED_ONE;
      hash_two <= bfti_pkg::SEED_TWO;
    end else if (ctl.key_end) begin
      hash_one <= bfti_pkg::SEED_ONE;
      hash_two <= bfti_pkg::SEED_TWO;
    end else if (ctl.hash_byte) begin
      hash_one <= hash_one_next;
      hash_two <= hash_two_next;
    end
  end

  // probe index: acc walks h1 + k*h2, reduced mod bit count by reciprocal
  assign mod_q   = mod_prod[63:32];
  assign mod_qb  = mod_q * BITS32;
  assign mod_fix = (mod_rem >= BITS2X) ? (mod_rem - BITS2X) :
                   (mod_rem >= BITS32) ? (mod_rem - BITS32) : mod_rem;

  always_ff @(posedge clk) begin
    if (ctl.key_end) begin
      acc  <= hash_one_next;
      step <= hash_two_next | 32'd1;
    end else if (ctl.test) begin
      acc  <= acc + step;
    end
    if (ctl.mul) begin
      mod_x    <= acc;
      mod_prod <= 64'(acc) * 64'(RECIP);
    end
    if (ctl.red) begin
      mod_rem <= mod_x - mod_qb;
    end
    if (ctl.fix) begin
      idx[k] <= mod_fix[BIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      all_set   <= 1'b1;
      untracked <= 1'b0;
    end else begin
      if (ctl.key_end) begin
        k       <= '0;
        all_set <= 1'b1;
      end else if (ctl.test || ctl.wr_set) begin
        k <= (k == K_LAST) ? '0 : k + K_W'(1);
      end
      if (ctl.test) begin
        all_set <= all_set & stat.bit_set;
      end
      if (ctl.untracked) begin
        untracked <= 1'b1;
      end else if (ctl.key_end) begin
        untracked <= 1'b0;
      end
    end
  end

  assign idx_k      = idx[k];
  assign idx_sh     = idx_k >> 3;
  assign probe_addr = idx_sh[ADDR_W-1:0];
  assign mask       = 8'd1 << idx_k[2:0];

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step && (clr_addr != CLR_LAST)) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign mem_we    = ctl.clr_step || ctl.wr_set;
  assign mem_waddr = ctl.clr_step ? clr_addr : probe_addr;
  assign mem_wdata = ctl.clr_step ? 8'd0 : (mem_rdata | mask);

  bfti_bitmap #(
    .DEPTH  (BITMAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (probe_addr),
    .rdata (mem_rdata)
  );

  // counters and result register
  assign is_ret = !untracked && all_set;
  assign is_new = !untracked && !all_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_det  <= '0;
      tot_uniq <= '0;
      ses_det  <= '0;
      ses_uniq <= '0;
      ses_ret  <= '0;
    end else if (ctl.emit) begin
      tot_det  <= tot_det + 32'd1;
      ses_det  <= ses_det + 32'd1;
      tot_uniq <= tot_uniq + 32'(is_new);
      ses_uniq <= ses_uniq + 32'(is_new);
      ses_ret  <= ses_ret + 32'(is_ret);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      returning         <= is_ret;
      det_total         <= tot_det + 32'd1;
      uniq_total        <= tot_uniq + 32'(is_new);
      det_since_rst     <= ses_det + 32'd1;
      uniq_since_rst    <= ses_uniq + 32'(is_new);
      session_returning <= ses_ret + 32'(is_ret);
    end
  end

  assign stat.clr_last = (clr_addr == CLR_LAST);
  assign stat.k_last   = (k == K_LAST);
  assign stat.bit_set  = mem_rdata[idx_k[2:0]];
  assign stat.all_set  = all_set;
  assign stat.out_free = !out_valid || !out_stall;

  `BFTI_ASSERT_NEXT(a_emit_loads, ctl.emit, out_valid)
  `BFTI_ASSERT_SAME(a_emit_slot_free, ctl.emit, !out_valid || !out_stall)
  `BFTI_ASSERT_SAME(a_set_only_new, ctl.wr_set, !all_set && !untracked)
  `BFTI_ASSERT_SAME(a_seeds_at_emit, ctl.emit && !untracked,
                    hash_one == bfti_pkg::SEED_ONE && hash_two == bfti_pkg::SEED_TWO)

endmodule

`default_nettype wire

FILE: rtl/bloom_filter_test_and_insert.sv
// ----------------------------------------------------------------------------
// bloom_filter_test_and_insert
// fnv-1a double-hashed bloom filter: test a streamed key, insert if new
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  input   | in_valid / in_stall | cmd, key_byte, last_byte
//  output  | out_valid/out_stall | returning, det_total, uniq_total,
//          |                     | det_since_rst, uniq_since_rst,
//          |                     | session_returning
//
//  a non-final key byte is absorbed in the idle step; an untracked
//  transaction goes straight to emit. a final key byte runs, for each of
//  the HASH_PROBES probes, a multiply, reduce, correct, read, test sequence
//  on the bitmap ram; a new key is then inserted by a read-modify-write per probe
//  after reset a clearing pass over BITMAP_BYTES bytes (49152 by default)
//  zeroes the bitmap, with in_stall high
//  results sit in an output register; while it is stalled transactions are
//  still taken until the next result is ready, which then waits in the emit
//  step with in_stall high
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_test_and_insert #(
  parameter int unsigned BITMAP_BYTES = bfti_pkg::BITMAP_BYTES_DEF,
  parameter int unsigned HASH_PROBES  = bfti_pkg::HASH_PROBES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  key_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             returning,
  output logic [31:0]      det_total,
  output logic [31:0]      uniq_total,
  output logic [31:0]      det_since_rst,
  output logic [31:0]      uniq_since_rst,
  output logic [31:0]      session_returning
);

  bfti_pkg::cmd_t  ctl;
  bfti_pkg::stat_t stat;

  bfti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .last_byte (last_byte),
    .stat      (stat),
    .ctl       (ctl)
  );

  bfti_dp #(
    .BITMAP_BYTES (BITMAP_BYTES),
    .HASH_PROBES  (HASH_PROBES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .key_byte          (key_byte),
    .ctl               (ctl),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .returning         (returning),
    .det_total         (det_total),
    .uniq_total        (uniq_total),
    .det_since_rst     (det_since_rst),
    .uniq_since_rst    (uniq_since_rst),
    .session_returning (session_returning)
  );

endmodule

`default_nettype wire
